### src/rrm64_pkg.sv
// ----------------------------------------------------------------------------
// rrm64_pkg
// Cipher tables and the single-round function used by the encrypt
// pipeline.
// ----------------------------------------------------------------------------
package rrm64_pkg;

  localparam int MAX_ROUNDS = 15;

  typedef logic [63:0] block_t;
  typedef logic [3:0]  nibble_t;
  typedef logic [1:0]  cfg_idx_t;

  // configuration register indexes
  localparam cfg_idx_t CFG_KEY_FIRST  = 2'd0;
  localparam cfg_idx_t CFG_KEY_SECOND = 2'd1;

  localparam nibble_t SBOX [16] = '{
    4'hc, 4'ha, 4'hd, 4'h3, 4'he, 4'hb, 4'hf, 4'h7,
    4'h8, 4'h9, 4'h1, 4'h5, 4'h0, 4'h2, 4'h4, 4'h6
  };

  // new cell i takes old cell SHUFFLE_SRC[i]
  localparam nibble_t SHUFFLE_SRC [16] = '{
    4'd0, 4'd10, 4'd5, 4'd15, 4'd14, 4'd4, 4'd11, 4'd1,
    4'd9, 4'd3, 4'd12, 4'd6, 4'd7, 4'd13, 4'd2, 4'd8
  };

  // round constants, cell 0 in the leftmost bit of each row
  localparam logic [15:0] RC [MAX_ROUNDS] = '{
    16'b0001_0101_1011_0011,
    16'b0111_1000_1100_0000,
    16'b1010_0100_0011_0101,
    16'b0110_0010_0001_0011,
    16'b0001_0000_0100_1111,
    16'b1101_0001_0111_0000,
    16'b0000_0010_0110_0110,
    16'b0000_1011_1100_1100,
    16'b1001_0100_1000_0001,
    16'b0100_0000_1011_1000,
    16'b0111_0001_1001_0111,
    16'b0010_0010_1000_1110,
    16'b0101_0001_0011_0000,
    16'b1111_1000_1100_1010,
    16'b1101_1111_1001_0000
  };

  // One full round: S-box, ShuffleCell, MixColumn, round-key and round-constant add.
  function automatic block_t rrm64_round(input block_t st, input nibble_t rnd,
                                         input block_t key);
    nibble_t sb [16];
    nibble_t sh [16];
    nibble_t col;
    block_t  res;
    res = '0;
    for (int i = 0; i < 16; i++) begin
      sb[i] = SBOX[st[(60 - 4 * i) +: 4]];
    end
    for (int i = 0; i < 16; i++) begin
      sh[i] = sb[SHUFFLE_SRC[i]];
    end
    for (int c = 0; c < 4; c++) begin
      col = sh[4 * c] ^ sh[4 * c + 1] ^ sh[4 * c + 2] ^ sh[4 * c + 3];
      for (int j = 0; j < 4; j++) begin
        res[(60 - 4 * (4 * c + j)) +: 4] = col ^ sh[4 * c + j]
            ^ key[(60 - 4 * (4 * c + j)) +: 4]
            ^ {3'b000, RC[rnd][15 - (4 * c + j)]};
      end
    end
    return res;
  endfunction

endpackage

### src/reduced_round_midori64_encrypt.sv
// ----------------------------------------------------------------------------
// reduced_round_midori64_encrypt
// Reduced-round Midori-64 encryption, one round per pipeline stage.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall / in_plaintext: a transfer happens on a
//   rising edge with in_valid high and in_stall low.
//   Output channel out_valid / out_stall / out_ciphertext: same rule, the
//   ciphertext comes straight from the last pipeline register.
//   Keys are written through cfg_we / cfg_index / cfg_wdata (index 0 is the
//   even-round key half, index 1 the odd-round half, other indexes dropped);
//   write them only while no block is in flight.
// Timing:
//   One input register followed by one register per round (ROUNDS of them,
//   at most 15). A block moves from the input register through each round
//   register in turn, and a new block can be taken every cycle while in_stall is low.
//   Round logic is one S-box layer, a cell shuffle, a column mix and the
//   key and constant XOR per cell, so each stage carries one round.
// Reset and stall:
//   rst_n low clears the keys to zero and empties the pipeline.
//   While out_stall holds a result, earlier stages keep filling any empty
//   slots; in_stall rises only once every stage is occupied.
// ----------------------------------------------------------------------------
module reduced_round_midori64_encrypt
  import rrm64_pkg::*;
#(
  parameter int ROUNDS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_plaintext,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_ciphertext,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  localparam int NR = (ROUNDS > MAX_ROUNDS) ? MAX_ROUNDS : ROUNDS;

  block_t key_first_r;
  block_t key_second_r;

  block_t data_r    [NR + 1];
  logic   valid_r   [NR + 1];
  block_t data_nxt  [NR + 1];
  logic   stage_rdy [NR + 1];

  // key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_first_r  <= '0;
      key_second_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_FIRST:  key_first_r  <= cfg_wdata;
        CFG_KEY_SECOND: key_second_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // a stage can load when it is empty or its content moves on this cycle
  assign stage_rdy[NR] = !valid_r[NR] || !out_stall;
  assign data_nxt[0]   = in_plaintext;

  genvar g;
  generate
    for (g = 0; g < NR; g++) begin : g_round
      assign stage_rdy[g]    = !valid_r[g] || stage_rdy[g + 1];
      assign data_nxt[g + 1] = rrm64_round(data_r[g], 4'(g),
                                           (g % 2 == 1) ? key_second_r : key_first_r);
    end

    for (g = 0; g <= NR; g++) begin : g_stage
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          valid_r[g] <= 1'b0;
        end else if (stage_rdy[g]) begin
          if (g == 0) begin
            valid_r[g] <= in_valid;
          end else begin
            valid_r[g] <= valid_r[(g == 0) ? 0 : g - 1];
          end
        end
      end

      // payload: no reset, hold while the stage is blocked
      always_ff @(posedge clk) begin
        if (stage_rdy[g]) begin
          data_r[g] <= data_nxt[g];
        end
      end
    end
  endgenerate

  assign in_stall       = !stage_rdy[0];
  assign out_valid      = valid_r[NR];
  assign out_ciphertext = data_r[NR];

endmodule

### src/rrm64_checker.sv
// ----------------------------------------------------------------------------
// rrm64_checker
// Port-level checks for the encrypt pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module rrm64_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_ciphertext
);

  // a held result stays put until its transfer
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_ciphertext))
    else $error("stalled result changed or dropped");

  // the pipeline comes out of reset empty
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // backpressure only starts at the output
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_stall && out_valid)
    else $error("input stalled while output drains");

  // a full pipeline blocked at the output keeps the input blocked next cycle while the output stays blocked
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall && out_stall && !in_valid |=> in_stall || !out_stall)
    else $error("input released while output still blocked");

endmodule

bind reduced_round_midori64_encrypt rrm64_checker u_rrm64_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_ciphertext (out_ciphertext)
);

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the reduced-round Midori-64 encrypt pipeline. Each
// accepted plaintext is encrypted by a local round model with the keys in
// force at that transfer, and every ciphertext is checked in order. Traffic
// runs with random idling on both sides, a long output hold-off and a full
// drain pause, and the keys are rewritten between phases while nothing is in
// flight.
// ----------------------------------------------------------------------------
module tb_top;
  import rrm64_pkg::block_t;
  import rrm64_pkg::nibble_t;
  import rrm64_pkg::cfg_idx_t;
  import rrm64_pkg::CFG_KEY_FIRST;
  import rrm64_pkg::CFG_KEY_SECOND;

  localparam int ROUNDS_N    = 4;
  localparam int RCON_ROWS   = 15;
  localparam int STUCK_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;

  // indexes past the two key registers, which the block drops
  localparam cfg_idx_t CFG_SPARE_LO = 2'd2;
  localparam cfg_idx_t CFG_SPARE_HI = 2'd3;

  localparam block_t ALL_ONES = 64'hffff_ffff_ffff_ffff;

  localparam nibble_t SUBST [16] = '{
    4'hc, 4'ha, 4'hd, 4'h3, 4'he, 4'hb, 4'hf, 4'h7,
    4'h8, 4'h9, 4'h1, 4'h5, 4'h0, 4'h2, 4'h4, 4'h6
  };

  localparam int CELL_SRC [16] = '{
    0, 10, 5, 15, 14, 4, 11, 1, 9, 3, 12, 6, 7, 13, 2, 8
  };

  // cell 0 sits in bit 15 of each row
  localparam logic [15:0] RCON [RCON_ROWS] = '{
    16'h15b3, 16'h78c0, 16'ha435, 16'h6213, 16'h104f,
    16'hd170, 16'h0266, 16'h0bcc, 16'h9481, 16'h40b8,
    16'h7197, 16'h228e, 16'h5130, 16'hf8ca, 16'hdf90
  };

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  block_t   in_plaintext = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  block_t   out_ciphertext;
  logic     cfg_we = 1'b0;
  cfg_idx_t cfg_index = CFG_KEY_FIRST;
  block_t   cfg_wdata = '0;

  block_t key_even = '0;
  block_t key_odd = '0;
  block_t expected_ct [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  int err_cnt = 0;
  int stuck_cycles = 0;

  reduced_round_midori64_encrypt #(
    .ROUNDS(ROUNDS_N)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_plaintext  (in_plaintext),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_ciphertext(out_ciphertext),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic block_t midori_encrypt(input block_t pt);
    nibble_t cells [16];
    nibble_t shuf [16];
    nibble_t colx;
    block_t  rkey;
    block_t  ct;
    int      nrounds;
    nrounds = (ROUNDS_N > RCON_ROWS) ? RCON_ROWS : ROUNDS_N;
    for (int j = 0; j < 16; j++) begin
      cells[j] = pt[60 - 4 * j +: 4];
    end
    for (int r = 0; r < nrounds; r++) begin
      rkey = r[0] ? key_odd : key_even;
      for (int j = 0; j < 16; j++) begin
        shuf[j] = SUBST[cells[CELL_SRC[j]]];
      end
      for (int c = 0; c < 16; c += 4) begin
        colx = shuf[c] ^ shuf[c + 1] ^ shuf[c + 2] ^ shuf[c + 3];
        for (int j = c; j < c + 4; j++) begin
          cells[j] = colx ^ shuf[j] ^ rkey[60 - 4 * j +: 4] ^ {3'b000, RCON[r][15 - j]};
        end
      end
    end
    ct = '0;
    for (int j = 0; j < 16; j++) begin
      ct[60 - 4 * j +: 4] = cells[j];
    end
    return ct;
  endfunction

  // Output side: random stall, or a counted hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_ct
    block_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_ct.size() == 0) begin
        $error("ciphertext %h with no block outstanding", out_ciphertext);
        err_cnt++;
      end else begin
        want = expected_ct.pop_front();
        if (out_ciphertext !== want) begin
          $error("ciphertext mismatch: expected %h, got %h", want, out_ciphertext);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic send_block(input block_t pt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_plaintext <= pt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_ct.push_back(midori_encrypt(pt));
  endtask

  // Drop valid and hold until every outstanding ciphertext has come back.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_ct.size() != 0) @(posedge clk);
    repeat (ROUNDS_N) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input block_t data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_KEY_FIRST:  key_even = data;
      CFG_KEY_SECOND: key_odd  = data;
      default: ;
    endcase
  endtask

  function automatic block_t rand_block();
    return {$urandom, $urandom};
  endfunction

  task automatic test_reset_keys();
    send_block('0);
    send_block(ALL_ONES);
    send_block(64'h0123_4567_89ab_cdef);
    send_block(64'haaaa_aaaa_aaaa_aaaa);
    send_block(64'h5555_5555_5555_5555);
  endtask

  task automatic test_key_extremes();
    wait_drain();
    write_reg(CFG_KEY_FIRST, ALL_ONES);
    write_reg(CFG_KEY_SECOND, '0);
    send_block('0);
    send_block(ALL_ONES);
    send_block(64'hfedc_ba98_7654_3210);
    wait_drain();
    write_reg(CFG_KEY_FIRST, '0);
    write_reg(CFG_KEY_SECOND, ALL_ONES);
    send_block('0);
    send_block(ALL_ONES);
    send_block(64'h8000_0000_0000_0001);
    wait_drain();
    write_reg(CFG_KEY_FIRST, 64'h5a5a_5a5a_5a5a_5a5a);
    write_reg(CFG_KEY_SECOND, 64'ha5a5_a5a5_a5a5_a5a5);
    send_block(64'h0f0f_0f0f_0f0f_0f0f);
    send_block(64'hf0f0_f0f0_f0f0_f0f0);
  endtask

  task automatic test_ignored_index();
    wait_drain();
    write_reg(CFG_SPARE_LO, ALL_ONES);
    write_reg(CFG_SPARE_HI, rand_block());
    send_block('0);
    send_block(ALL_ONES);
    send_block(rand_block());
  endtask

  task automatic test_random_traffic(input int count, input int s_pct, input int r_pct);
    wait_drain();
    write_reg(CFG_KEY_FIRST, rand_block());
    write_reg(CFG_KEY_SECOND, rand_block());
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (count) send_block(rand_block());
  endtask

  // Stall the output long enough for the pipeline to fill and push back.
  task automatic test_backpressure();
    wait_drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = HOLD_CYCLES;
    repeat (40) send_block(rand_block());
  endtask

  task automatic test_drain_pause();
    send_idle_pct = 10;
    recv_idle_pct = 20;
    repeat (20) send_block(rand_block());
    wait_drain();
    repeat (20) send_block(rand_block());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_keys();
    test_key_extremes();
    test_ignored_index();
    test_random_traffic(310, 32, 87);
    test_random_traffic(310, 87, 32);
    test_random_traffic(310, 0, 0);
    test_backpressure();
    test_drain_pause();
    wait_drain();
    repeat (4) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
